// File: hdl/crf_pkg.sv
// Shared constants and a helper function for the command frame receiver.
package crf_pkg;

   // Default sizes for the top-level parameters.
   localparam int PAYLOAD_LIMIT_DEF = 50;
   localparam int STORED_BYTES_DEF  = 20;

   // Configuration register map.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_FAILSAFE_PERIOD = 1'b0;
   localparam logic [7:0] FAILSAFE_PERIOD_RST = 8'd30;

   // Parser phases.
   localparam logic [2:0] PH_HUNT = 3'd0;
   localparam logic [2:0] PH_HDR2 = 3'd1;
   localparam logic [2:0] PH_FUNC = 3'd2;
   localparam logic [2:0] PH_LEN  = 3'd3;
   localparam logic [2:0] PH_DATA = 3'd4;
   localparam logic [2:0] PH_CSUM = 3'd5;

   // Frame bytes.
   localparam logic [7:0] HDR_BYTE1 = 8'hAA;
   localparam logic [7:0] HDR_BYTE2 = 8'hAF;
   localparam logic [7:0] FN_MIN    = 8'h01;
   localparam logic [7:0] FN_MAX    = 8'hF0;

   // Function codes.
   localparam logic [7:0] FN_CMD    = 8'h01;
   localparam logic [7:0] FN_REPORT = 8'h02;
   localparam logic [7:0] FN_RC     = 8'h03;
   localparam logic [7:0] FN_GAIN_A = 8'h10;
   localparam logic [7:0] FN_GAIN_B = 8'h11;
   localparam logic [7:0] FN_ACK_LO = 8'h12;
   localparam logic [7:0] FN_ACK_HI = 8'h15;

   // Command operands.
   localparam logic [7:0] OP_CAL_ACC    = 8'h01;
   localparam logic [7:0] OP_CAL_GYRO   = 8'h02;
   localparam logic [7:0] OP_CAL_BOTH   = 8'h03;
   localparam logic [7:0] OP_DISARM     = 8'hA0;
   localparam logic [7:0] OP_ARM        = 8'hA1;
   localparam logic [7:0] OP_GAIN_QUERY = 8'h01;

   // Payload sizes, last word indices and the gain B index base.
   localparam logic [5:0] RC_BYTES    = 6'd20;
   localparam logic [5:0] GAIN_BYTES  = 6'd18;
   localparam logic [3:0] RC_LAST     = 4'd9;
   localparam logic [3:0] GAIN_LAST   = 4'd8;
   localparam logic [4:0] GAIN_B_BASE = 5'd9;

   // Result kinds.
   localparam logic [1:0] KIND_STATUS = 2'd0;
   localparam logic [1:0] KIND_CHAN   = 2'd1;
   localparam logic [1:0] KIND_GAIN   = 2'd2;
   localparam logic [1:0] KIND_ACK    = 2'd3;

   // Frame status codes.
   localparam logic [1:0] FS_NONE     = 2'd0;
   localparam logic [1:0] FS_ACCEPT   = 2'd1;
   localparam logic [1:0] FS_CSUM_ERR = 2'd2;
   localparam logic [1:0] FS_LEN_REJ  = 2'd3;

   // Acknowledge frame: fixed bytes, then the received checksum and its own sum.
   localparam logic [7:0] ACK_B0 = 8'hAA;
   localparam logic [7:0] ACK_B1 = 8'hAA;
   localparam logic [7:0] ACK_B2 = 8'hF0;
   localparam logic [7:0] ACK_B3 = 8'h03;
   localparam logic [7:0] ACK_B4 = 8'hBA;
   localparam logic [7:0] ACK_B5 = 8'h00;
   localparam logic [7:0] ACK_SUM_BASE =
      8'((ACK_B0 + ACK_B1 + ACK_B2 + ACK_B3 + ACK_B4 + ACK_B5) % 256);
   localparam logic [2:0] ACK_LAST = 3'd7;

   function automatic logic [7:0] ack_byte(input logic [2:0] idx, input logic [7:0] sum);
      logic [7:0] b;
      case (idx)
         3'd0: b = ACK_B0;
         3'd1: b = ACK_B1;
         3'd2: b = ACK_B2;
         3'd3: b = ACK_B3;
         3'd4: b = ACK_B4;
         3'd5: b = ACK_B5;
         3'd6: b = sum;
         3'd7: b = sum + ACK_SUM_BASE;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

// File: hdl/crf_ram.sv
// Generic single-clock RAM with one write port and a registered read port.
module crf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 20
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/command_frame_receiver_unit.sv
// Top level of the command frame receiver: byte parser, failsafe timer and result sequencer.
//
//  Channel  Direction  Handshake                    Contents
//  req      in         req_tvalid / req_tready      tdata: rx_byte; tuser: opcode
//  rsp      out        rsp_tvalid / rsp_tready      tdata: index..save_request; tuser: kind
//  csr      in/out     APB, csr_pready always high  failsafe_period at byte address 0
//
// An input transaction that yields a single status result is first accepted and updates
// the parser, then loads the output register. An accepted command frame (function 01 or
// 02) reads its operand back from the payload RAM and decodes it before its status is
// loaded. Channel and gain writes make two RAM reads of the payload RAM's single read
// port per 16-bit value; ack bytes are loaded one by one as the output register frees.
// Reset is synchronous and active high; it restores the parser to header hunting, clears
// the flags and the tick count and sets failsafe_period to 30. The payload RAM is not
// cleared. A stalled rsp side holds the sequencer; a new input transaction is taken only
// after all results of the previous one have been loaded into the output register.
module command_frame_receiver_unit #(
   parameter int PAYLOAD_LIMIT = crf_pkg::PAYLOAD_LIMIT_DEF,
   parameter int STORED_BYTES  = crf_pkg::STORED_BYTES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   // Input stream.
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [7:0]                    req_tdata,   // [7:0] rx_byte
   input  logic [0:0]                    req_tuser,   // [0] opcode (0 byte, 1 tick)
   // Result stream.
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // [4:0] index, [20:5] value, [22:21] frame_status, [23] armed, [24] failsafe,
   // [25] acc_cal_request, [26] gyro_cal_request, [27] gain_report_request,
   // [28] save_request, [31:29] zero
   output logic [31:0]                   rsp_tdata,
   output logic [1:0]                    rsp_tuser,   // [1:0] kind
   output logic                          rsp_tlast,
   // Configuration port.
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [crf_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [crf_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [crf_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                          csr_pready
);

   localparam int ADDR_W = $clog2(STORED_BYTES);
   localparam logic [7:0] LIMIT_BYTE = 8'(PAYLOAD_LIMIT);
   localparam logic [5:0] STORED_CNT = 6'(STORED_BYTES);

   // Sequencer states.
   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SINGLE = 3'd1;
   localparam logic [2:0] ST_OP_RD  = 3'd2;
   localparam logic [2:0] ST_OP     = 3'd3;
   localparam logic [2:0] ST_RD_HI  = 3'd4;
   localparam logic [2:0] ST_RD_LO  = 3'd5;
   localparam logic [2:0] ST_WORD   = 3'd6;
   localparam logic [2:0] ST_ACK    = 3'd7;

   // Control and parser state.
   logic [2:0] state_ff, state_in;
   logic [2:0] phase_ff, phase_in;
   logic [7:0] func_ff, func_in;
   logic [5:0] len_ff, len_in;
   logic [5:0] count_ff, count_in;
   logic [7:0] sum_ff, sum_in;
   logic       armed_ff, armed_in;
   logic       failsafe_ff, failsafe_in;
   logic [7:0] tick_ff, tick_in;
   logic [7:0] period_ff, period_in;

   // Sequencer working registers.
   logic [1:0] status_ff, status_in;
   logic [2:0] pulses_ff, pulses_in;    // bit 0 acc, bit 1 gyro, bit 2 gain report
   logic       gain_ff, gain_in;        // word run carries gains rather than channels
   logic [4:0] base_ff, base_in;
   logic [3:0] word_ff, word_in;
   logic [2:0] ack_ff, ack_in;
   logic [7:0] hi_ff, hi_in;

   // Output register.
   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  o_kind_ff, o_kind_in;
   logic [4:0]  o_index_ff, o_index_in;
   logic [15:0] o_value_ff, o_value_in;
   logic [1:0]  o_status_ff, o_status_in;
   logic        o_armed_ff, o_armed_in;
   logic        o_failsafe_ff, o_failsafe_in;
   logic [3:0]  o_pulses_ff, o_pulses_in;  // acc, gyro, gain report, save
   logic        o_last_ff, o_last_in;

   // Payload RAM ports.
   logic              ram_wr_en;
   logic [ADDR_W-1:0] ram_wr_addr;
   logic [ADDR_W-1:0] ram_rd_addr;
   logic [7:0]        ram_rd_data;

   logic       in_accept;
   logic       slot_free;
   logic       csr_write;
   logic [7:0] rx_byte;
   logic [5:0] count_next;
   logic [3:0] word_last;

   crf_ram #(
      .WIDTH (8),
      .DEPTH (STORED_BYTES)
   ) u_payload_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (rx_byte),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rx_byte    = req_tdata;
   assign req_tready = (state_ff == ST_IDLE);
   assign in_accept  = req_tvalid && req_tready;
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign count_next = count_ff + 6'd1;
   assign word_last  = gain_ff ? crf_pkg::GAIN_LAST : crf_pkg::RC_LAST;

   // The configuration register is written at the access phase; only register 0 exists.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == crf_pkg::REG_FAILSAFE_PERIOD)
                       ? {{(crf_pkg::CSR_DATA_W-8){1'b0}}, period_ff}
                       : '0;

   // Payload bytes go to the RAM at their position in the payload; bytes past the store
   // are only summed.
   assign ram_wr_addr = count_ff[ADDR_W-1:0];

   // Read address: the high byte of a word is at the even position, the low byte after it.
   always_comb begin
      case (state_ff)
         ST_RD_HI: ram_rd_addr = ADDR_W'({word_ff, 1'b0});
         ST_RD_LO: ram_rd_addr = ADDR_W'({word_ff, 1'b1});
         ST_WORD:  ram_rd_addr = ADDR_W'({word_ff, 1'b1});
         default:  ram_rd_addr = '0;
      endcase
   end

   always_comb begin
      state_in    = state_ff;
      phase_in    = phase_ff;
      func_in     = func_ff;
      len_in      = len_ff;
      count_in    = count_ff;
      sum_in      = sum_ff;
      armed_in    = armed_ff;
      failsafe_in = failsafe_ff;
      tick_in     = tick_ff;
      period_in   = period_ff;
      status_in   = status_ff;
      pulses_in   = pulses_ff;
      gain_in     = gain_ff;
      base_in     = base_ff;
      word_in     = word_ff;
      ack_in      = ack_ff;
      hi_in       = hi_ff;
      ram_wr_en   = 1'b0;

      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      o_kind_in     = o_kind_ff;
      o_index_in    = o_index_ff;
      o_value_in    = o_value_ff;
      o_status_in   = o_status_ff;
      o_armed_in    = o_armed_ff;
      o_failsafe_in = o_failsafe_ff;
      o_pulses_in   = o_pulses_ff;
      o_last_in     = o_last_ff;

      if (csr_write && (csr_paddr[2] == crf_pkg::REG_FAILSAFE_PERIOD)) begin
         period_in = csr_pwdata[7:0];
      end

      case (state_ff)
         ST_IDLE: begin
            if (in_accept) begin
               status_in = crf_pkg::FS_NONE;
               pulses_in = 3'b000;
               state_in  = ST_SINGLE;
               if (req_tuser[0]) begin
                  // Failsafe tick: an overrun raises failsafe first, then disarms.
                  if (tick_ff > period_ff) begin
                     tick_in = 8'd1;
                     if (!failsafe_ff) begin
                        failsafe_in = 1'b1;
                     end else begin
                        armed_in = 1'b0;
                     end
                  end else begin
                     tick_in = tick_ff + 8'd1;
                  end
               end else begin
                  case (phase_ff)
                     crf_pkg::PH_HDR2: begin
                        if (rx_byte == crf_pkg::HDR_BYTE2) begin
                           sum_in   = sum_ff + rx_byte;
                           phase_in = crf_pkg::PH_FUNC;
                        end else if (rx_byte == crf_pkg::HDR_BYTE1) begin
                           sum_in = rx_byte;
                        end else begin
                           phase_in = crf_pkg::PH_HUNT;
                        end
                     end
                     crf_pkg::PH_FUNC: begin
                        if (rx_byte >= crf_pkg::FN_MIN && rx_byte <= crf_pkg::FN_MAX) begin
                           func_in  = rx_byte;
                           sum_in   = sum_ff + rx_byte;
                           phase_in = crf_pkg::PH_LEN;
                        end else begin
                           phase_in = crf_pkg::PH_HUNT;
                        end
                     end
                     crf_pkg::PH_LEN: begin
                        if (rx_byte >= LIMIT_BYTE) begin
                           status_in = crf_pkg::FS_LEN_REJ;
                           phase_in  = crf_pkg::PH_HUNT;
                        end else begin
                           len_in   = rx_byte[5:0];
                           count_in = 6'd0;
                           sum_in   = sum_ff + rx_byte;
                           phase_in = (rx_byte[5:0] != 6'd0) ? crf_pkg::PH_DATA
                                                             : crf_pkg::PH_CSUM;
                        end
                     end
                     crf_pkg::PH_DATA: begin
                        ram_wr_en = (count_ff < STORED_CNT);
                        sum_in    = sum_ff + rx_byte;
                        count_in  = count_next;
                        if (count_next >= len_ff) begin
                           phase_in = crf_pkg::PH_CSUM;
                        end
                     end
                     crf_pkg::PH_CSUM: begin
                        phase_in = crf_pkg::PH_HUNT;
                        if (rx_byte == sum_ff) begin
                           // Good frame: clear failsafe and pick the action.
                           failsafe_in = 1'b0;
                           status_in   = crf_pkg::FS_ACCEPT;
                           word_in     = 4'd0;
                           ack_in      = 3'd0;
                           if ((func_ff == crf_pkg::FN_CMD || func_ff == crf_pkg::FN_REPORT)
                               && len_ff != 6'd0) begin
                              state_in = ST_OP_RD;
                           end else if (func_ff == crf_pkg::FN_RC &&
                                        len_ff >= crf_pkg::RC_BYTES) begin
                              gain_in  = 1'b0;
                              base_in  = 5'd0;
                              state_in = ST_RD_HI;
                           end else if ((func_ff == crf_pkg::FN_GAIN_A ||
                                         func_ff == crf_pkg::FN_GAIN_B) &&
                                        len_ff >= crf_pkg::GAIN_BYTES) begin
                              gain_in  = 1'b1;
                              base_in  = (func_ff == crf_pkg::FN_GAIN_B) ?
                                         crf_pkg::GAIN_B_BASE : 5'd0;
                              state_in = ST_RD_HI;
                           end else if (func_ff >= crf_pkg::FN_ACK_LO &&
                                        func_ff <= crf_pkg::FN_ACK_HI) begin
                              state_in = ST_ACK;
                           end
                        end else begin
                           status_in = crf_pkg::FS_CSUM_ERR;
                        end
                     end
                     default: begin
                        // Hunting, and any phase code that means nothing.
                        phase_in = crf_pkg::PH_HUNT;
                        if (rx_byte == crf_pkg::HDR_BYTE1) begin
                           sum_in   = rx_byte;
                           phase_in = crf_pkg::PH_HDR2;
                        end
                     end
                  endcase
               end
            end
         end

         ST_SINGLE: begin
            // One status result carrying the pulses and the flags as they now stand.
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               o_kind_in     = crf_pkg::KIND_STATUS;
               o_index_in    = 5'd0;
               o_value_in    = 16'd0;
               o_status_in   = status_ff;
               o_armed_in    = armed_ff;
               o_failsafe_in = failsafe_ff;
               o_pulses_in   = {1'b0, pulses_ff};
               o_last_in     = 1'b1;
               state_in      = ST_IDLE;
            end
         end

         ST_OP_RD: begin
            state_in = ST_OP;
         end

         ST_OP: begin
            // The first payload byte is on the RAM output now.
            if (func_ff == crf_pkg::FN_CMD) begin
               case (ram_rd_data)
                  crf_pkg::OP_CAL_ACC:  pulses_in = 3'b001;
                  crf_pkg::OP_CAL_GYRO: pulses_in = 3'b010;
                  crf_pkg::OP_CAL_BOTH: pulses_in = 3'b011;
                  crf_pkg::OP_DISARM:   armed_in  = 1'b0;
                  crf_pkg::OP_ARM:      armed_in  = 1'b1;
                  default:              pulses_in = 3'b000;
               endcase
            end else if (ram_rd_data == crf_pkg::OP_GAIN_QUERY) begin
               pulses_in = 3'b100;
            end
            state_in = ST_SINGLE;
         end

         ST_RD_HI: begin
            state_in = ST_RD_LO;
         end

         ST_RD_LO: begin
            hi_in    = ram_rd_data;
            state_in = ST_WORD;
         end

         ST_WORD: begin
            // The low byte stays on the RAM output while the output register is busy.
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               o_kind_in     = gain_ff ? crf_pkg::KIND_GAIN : crf_pkg::KIND_CHAN;
               o_index_in    = base_ff + {1'b0, word_ff};
               o_value_in    = {hi_ff, ram_rd_data};
               o_status_in   = crf_pkg::FS_ACCEPT;
               o_armed_in    = armed_ff;
               o_failsafe_in = failsafe_ff;
               o_pulses_in   = {gain_ff && (word_ff == crf_pkg::GAIN_LAST), 3'b000};
               o_last_in     = !gain_ff && (word_ff == crf_pkg::RC_LAST);
               if (word_ff == word_last) begin
                  state_in = gain_ff ? ST_ACK : ST_IDLE;
               end else begin
                  word_in  = word_ff + 4'd1;
                  state_in = ST_RD_HI;
               end
            end
         end

         ST_ACK: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               o_kind_in     = crf_pkg::KIND_ACK;
               o_index_in    = 5'd0;
               o_value_in    = {8'd0, crf_pkg::ack_byte(ack_ff, sum_ff)};
               o_status_in   = crf_pkg::FS_ACCEPT;
               o_armed_in    = armed_ff;
               o_failsafe_in = failsafe_ff;
               o_pulses_in   = 4'b0000;
               o_last_in     = (ack_ff == crf_pkg::ACK_LAST);
               ack_in        = ack_ff + 3'd1;
               if (ack_ff == crf_pkg::ACK_LAST) begin
                  state_in = ST_IDLE;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= crf_pkg::PH_HUNT;
         func_ff      <= 8'd0;
         len_ff       <= 6'd0;
         count_ff     <= 6'd0;
         sum_ff       <= 8'd0;
         armed_ff     <= 1'b0;
         failsafe_ff  <= 1'b0;
         tick_ff      <= 8'd0;
         period_ff    <= crf_pkg::FAILSAFE_PERIOD_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         func_ff      <= func_in;
         len_ff       <= len_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         armed_ff     <= armed_in;
         failsafe_ff  <= failsafe_in;
         tick_ff      <= tick_in;
         period_ff    <= period_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff     <= status_in;
      pulses_ff     <= pulses_in;
      gain_ff       <= gain_in;
      base_ff       <= base_in;
      word_ff       <= word_in;
      ack_ff        <= ack_in;
      hi_ff         <= hi_in;
      o_kind_ff     <= o_kind_in;
      o_index_ff    <= o_index_in;
      o_value_ff    <= o_value_in;
      o_status_ff   <= o_status_in;
      o_armed_ff    <= o_armed_in;
      o_failsafe_ff <= o_failsafe_in;
      o_pulses_ff   <= o_pulses_in;
      o_last_ff     <= o_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = o_kind_ff;
   assign rsp_tlast  = o_last_ff;
   assign rsp_tdata  = {3'b000, o_pulses_ff, o_failsafe_ff, o_armed_ff, o_status_ff,
                        o_value_ff, o_index_ff};

endmodule
